### rtl/i128_pkg.sv
// ----------------------------------------------------------------------------
// i128_pkg
// Shared types and constants of the 128-bit integer ALU.
// ----------------------------------------------------------------------------
package i128_pkg;

    localparam int WORD_BITS = 128;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int SHIFT_BITS = $clog2(WORD_BITS);

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_AND  = 4'd4,
        OP_OR   = 4'd5,
        OP_XOR  = 4'd6,
        OP_NOT  = 4'd7,
        OP_SHL  = 4'd8,
        OP_SAR  = 4'd9,
        OP_ROL1 = 4'd10,
        OP_ROR1 = 4'd11
    } t_op;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_MUL,
        MODE_DIV
    } t_mode;

    typedef struct packed {
        logic [3:0]            opcode;
        logic [HALF_BITS-1:0]  a_hi;
        logic [HALF_BITS-1:0]  a_lo;
        logic [HALF_BITS-1:0]  b_hi;
        logic [HALF_BITS-1:0]  b_lo;
        logic [SHIFT_BITS-1:0] shift_amount;
    } t_req;

    typedef struct packed {
        logic [HALF_BITS-1:0] result_hi;
        logic [HALF_BITS-1:0] result_lo;
        logic                 divide_by_zero;
    } t_res;

    // Data handed from one chain cell to the next.
    typedef struct packed {
        logic                 vld;
        t_mode                mode;
        logic                 neg;
        logic                 dz;
        logic                 pbit;
        logic [WORD_BITS-1:0] w0;
        logic [WORD_BITS-1:0] w1;
        logic [WORD_BITS-1:0] w2;
    } t_cell;

endpackage

### rtl/i128_pre.sv
// ----------------------------------------------------------------------------
// i128_pre
// Input stage: chain operands (magnitudes for divide) and the results of all other operations.
// ----------------------------------------------------------------------------
module i128_pre (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  i128_pkg::t_req i_req,
    output i128_pkg::t_cell o_cell
);

    i128_pkg::t_cell r_cell, n_cell;
    logic [i128_pkg::WORD_BITS-1:0] a, b;
    logic na, nb;

    assign a  = {i_req.a_hi, i_req.a_lo};
    assign b  = {i_req.b_hi, i_req.b_lo};
    assign na = a[i128_pkg::WORD_BITS-1];
    assign nb = b[i128_pkg::WORD_BITS-1];

    always_comb begin
        n_cell      = '0;
        // Reset clears only the valid bit; the data simply flows.
        n_cell.vld  = i_vld & i_rst_n;
        n_cell.mode = i128_pkg::MODE_PASS;
        case (i_req.opcode)
            i128_pkg::OP_ADD:  n_cell.w0 = a + b;
            i128_pkg::OP_SUB:  n_cell.w0 = a - b;
            i128_pkg::OP_MUL: begin
                n_cell.mode = i128_pkg::MODE_MUL;
                n_cell.w1   = a;
                n_cell.w2   = b;
            end
            i128_pkg::OP_DIV: begin
                n_cell.mode = i128_pkg::MODE_DIV;
                n_cell.w1   = na ? (~a + 1'b1) : a;
                n_cell.w2   = nb ? (~b + 1'b1) : b;
                n_cell.neg  = na ^ nb;
                n_cell.dz   = (b == '0);
            end
            i128_pkg::OP_AND:  n_cell.w0 = a & b;
            i128_pkg::OP_OR:   n_cell.w0 = a | b;
            i128_pkg::OP_XOR:  n_cell.w0 = a ^ b;
            i128_pkg::OP_NOT:  n_cell.w0 = ~a;
            i128_pkg::OP_SHL:  n_cell.w0 = a << i_req.shift_amount;
            i128_pkg::OP_SAR:  n_cell.w0 = $unsigned($signed(a) >>> i_req.shift_amount);
            i128_pkg::OP_ROL1: n_cell.w0 = {a[i128_pkg::WORD_BITS-2:0],
                                            a[i128_pkg::WORD_BITS-1]};
            i128_pkg::OP_ROR1: n_cell.w0 = {a[0], a[i128_pkg::WORD_BITS-1:1]};
            default:           n_cell.w0 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

### rtl/i128_cell.sv
// ----------------------------------------------------------------------------
// i128_cell
// One chain cell: a Booth multiply step, a restoring divide step, or a plain pass.
// ----------------------------------------------------------------------------
module i128_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  i128_pkg::t_cell i_cell,
    output i128_pkg::t_cell o_cell
);

    localparam int W = i128_pkg::WORD_BITS;

    i128_pkg::t_cell r_cell, n_cell;
    logic [W-1:0] rem2, x, y;
    logic [W:0]   sum;
    logic         cin, bsub, badd;

    // Booth recoding of the current multiplier bit and the one below it.
    assign bsub = i_cell.w2[0] & ~i_cell.pbit;
    assign badd = ~i_cell.w2[0] & i_cell.pbit;
    assign rem2 = {i_cell.w0[W-2:0], i_cell.w1[W-1]};

    always_comb begin
        if (i_cell.mode == i128_pkg::MODE_DIV) begin
            x   = rem2;
            y   = ~i_cell.w2;
            cin = 1'b1;
        end else begin
            x   = i_cell.w0;
            y   = bsub ? ~i_cell.w1 : i_cell.w1;
            cin = bsub;
        end
    end

    assign sum = {1'b0, x} + {1'b0, y} + {{W{1'b0}}, cin};

    always_comb begin
        n_cell = i_cell;
        case (i_cell.mode)
            i128_pkg::MODE_MUL: begin
                if (bsub || badd) begin
                    n_cell.w0 = sum[W-1:0];
                end
                n_cell.w1   = {i_cell.w1[W-2:0], 1'b0};
                n_cell.w2   = {1'b0, i_cell.w2[W-1:1]};
                n_cell.pbit = i_cell.w2[0];
            end
            i128_pkg::MODE_DIV: begin
                // Carry out set means no borrow: the divisor fits.
                n_cell.w0 = sum[W] ? sum[W-1:0] : rem2;
                n_cell.w1 = {i_cell.w1[W-2:0], sum[W]};
            end
            default: n_cell = i_cell;
        endcase
        n_cell.vld = i_cell.vld & i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_cell = r_cell;

endmodule

### rtl/i128_post.sv
// ----------------------------------------------------------------------------
// i128_post
// Output stage: quotient sign, divide-by-zero and the result register.
// ----------------------------------------------------------------------------
module i128_post (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  i128_pkg::t_cell i_cell,
    output logic            o_done,
    output i128_pkg::t_res  o_res
);

    localparam int H = i128_pkg::HALF_BITS;

    i128_pkg::t_res r_res, n_res;
    logic           r_done;
    logic [i128_pkg::WORD_BITS-1:0] val;

    always_comb begin
        val = i_cell.w0;
        if (i_cell.mode == i128_pkg::MODE_DIV) begin
            if (i_cell.dz) begin
                val = '0;
            end else begin
                val = i_cell.neg ? (~i_cell.w1 + 1'b1) : i_cell.w1;
            end
        end
        n_res.result_hi      = val[2*H-1:H];
        n_res.result_lo      = val[H-1:0];
        n_res.divide_by_zero = (i_cell.mode == i128_pkg::MODE_DIV) & i_cell.dz;
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cell.vld;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### rtl/int128_alu_unit.sv
// ----------------------------------------------------------------------------
// int128_alu_unit
// Every opcode takes the same path from start to done.
// Throughput: one request per cycle; busy is always low and the pipe never
// stalls, since the receiver takes each result in its single done cycle.
// Reset (synchronous, active low) clears only the valid bits of the pipe.
// ----------------------------------------------------------------------------
module int128_alu_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  i128_pkg::t_req i_req,
    output logic           o_done,
    output i128_pkg::t_res o_res
);

    localparam int W = i128_pkg::WORD_BITS;

    // The chain: link k feeds cell k. Multiply runs one Booth step per cell
    // (add, subtract or keep a shifted copy of A), and divide runs one
    // restoring step per cell on the magnitudes. Every other operation is
    // finished in the input stage and rides the chain unchanged so that all
    // results leave in request order.
    i128_pkg::t_cell link [W+1];

    // The pipeline never refuses a request.
    assign o_busy = 1'b0;

    i128_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start),
        .i_req   (i_req),
        .o_cell  (link[0])
    );

    for (genvar k = 0; k < W; k++) begin : g_cell
        i128_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (link[k]),
            .o_cell  (link[k+1])
        );
    end

    // The output stage fixes the quotient sign and forces a zero result
    // when the divisor was zero.
    i128_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (link[W]),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for int128_alu_unit. Requests go in through the
// start/busy handshake. A predictor computes each expected result, and a
// checker compares every done strobe against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = i128_pkg::WORD_BITS + 2;
    localparam int CYCLE_LIMIT = 400000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_start;
    logic           o_busy;
    i128_pkg::t_req i_req;
    logic           o_done;
    i128_pkg::t_res o_res;

    // Results still owed by the pipe, oldest first.
    i128_pkg::t_res pending_results[$];
    int   fail_count;
    int   cycle_count;
    int   idle_pct;

    int128_alu_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy (o_busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_res  (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog. A correct run finishes far below this cycle count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("int128_alu_unit verification failed");
            $finish;
        end
    end

    // Signed division with truncation toward zero, done on the magnitudes.
    function automatic logic [127:0] quotient_of(logic [127:0] a, logic [127:0] b);
        logic [127:0] mag_a;
        logic [127:0] mag_b;
        logic [127:0] q;
        mag_a = a[127] ? -a : a;
        mag_b = b[127] ? -b : b;
        q = mag_a / mag_b;
        return (a[127] ^ b[127]) ? -q : q;
    endfunction

    // Predicts the result of one request.
    function automatic i128_pkg::t_res alu_result(i128_pkg::t_req req);
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] r;
        i128_pkg::t_res res;
        a = {req.a_hi, req.a_lo};
        b = {req.b_hi, req.b_lo};
        r = '0;
        res.divide_by_zero = 1'b0;
        case (req.opcode)
            i128_pkg::OP_ADD: r = a + b;
            i128_pkg::OP_SUB: r = a - b;
            i128_pkg::OP_MUL: r = a * b;
            i128_pkg::OP_DIV: begin
                // A zero divisor raises the flag and leaves the result at zero.
                if (b == '0) res.divide_by_zero = 1'b1;
                else r = quotient_of(a, b);
            end
            i128_pkg::OP_AND:  r = a & b;
            i128_pkg::OP_OR:   r = a | b;
            i128_pkg::OP_XOR:  r = a ^ b;
            i128_pkg::OP_NOT:  r = ~a;
            i128_pkg::OP_SHL:  r = a << req.shift_amount;
            i128_pkg::OP_SAR:  r = $signed(a) >>> req.shift_amount;
            i128_pkg::OP_ROL1: r = {a[126:0], a[127]};
            i128_pkg::OP_ROR1: r = {a[0], a[127:1]};
            default: r = '0;
        endcase
        res.result_hi = r[127:64];
        res.result_lo = r[63:0];
        return res;
    endfunction

    // Checker: every done strobe must match the oldest expectation.
    always @(posedge i_clk) begin
        i128_pkg::t_res want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: expected no result, actual %h", $time, o_res);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_res.result_hi !== want.result_hi) begin
                    $display("%0t: result_hi expected %h actual %h",
                             $time, want.result_hi, o_res.result_hi);
                    fail_count++;
                end
                if (o_res.result_lo !== want.result_lo) begin
                    $display("%0t: result_lo expected %h actual %h",
                             $time, want.result_lo, o_res.result_lo);
                    fail_count++;
                end
                if (o_res.divide_by_zero !== want.divide_by_zero) begin
                    $display("%0t: divide_by_zero expected %b actual %b",
                             $time, want.divide_by_zero, o_res.divide_by_zero);
                    fail_count++;
                end
            end
        end
    end

    // Sends one request. Start stays high across back-to-back requests and
    // drops only when the sender decides to idle or a burst ends.
    task automatic send_request(i128_pkg::t_req req);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= req;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_results.push_back(alu_result(req));
    endtask

    task automatic end_burst();
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [127:0] random_word();
        logic [127:0] w;
        w = {$urandom, $urandom, $urandom, $urandom};
        // Skew some operands toward corners and small magnitudes.
        case ($urandom_range(7))
            0: w = '0;
            1: w = '1;
            2: w = {1'b1, 127'd0};
            3: w = {1'b0, {127{1'b1}}};
            4: w = {{96{w[127]}}, w[31:0]};
            5: w = 128'(w[15:0]);
            default: ;
        endcase
        return w;
    endfunction

    function automatic i128_pkg::t_req make_request(i128_pkg::t_op op, logic [127:0] a,
                                                    logic [127:0] b, logic [6:0] shamt);
        i128_pkg::t_req req;
        req.opcode       = op;
        req.a_hi         = a[127:64];
        req.a_lo         = a[63:0];
        req.b_hi         = b[127:64];
        req.b_lo         = b[63:0];
        req.shift_amount = shamt;
        return req;
    endfunction

    // Corner operands for every opcode, plus the named special cases.
    task automatic test_directed();
        logic [127:0] min_neg;
        logic [127:0] ops_a[4];
        i128_pkg::t_req req;
        min_neg = {1'b1, 127'd0};
        ops_a = '{'0, '1, min_neg, ~min_neg};
        for (int op = i128_pkg::OP_ADD; op <= i128_pkg::OP_ROR1; op++) begin
            send_request(make_request(i128_pkg::t_op'(op), ops_a[op % 4],
                                      ops_a[(op + 1) % 4], 7'(op * 11)));
        end
        send_request(make_request(i128_pkg::OP_DIV, 128'd1234, '0, '0));
        send_request(make_request(i128_pkg::OP_DIV, min_neg, '1, '0));
        send_request(make_request(i128_pkg::OP_DIV, -128'sd7, 128'd2, '0));
        send_request(make_request(i128_pkg::OP_SHL, ops_a[3], '0, 7'd0));
        send_request(make_request(i128_pkg::OP_SAR, min_neg, '0, 7'd0));
        send_request(make_request(i128_pkg::OP_SAR, min_neg, '0, 7'd127));
        send_request(make_request(i128_pkg::OP_SHL, '1, '0, 7'd127));
        send_request(make_request(i128_pkg::OP_MUL, min_neg, '1, '0));
        // Unused opcodes give zero.
        for (int op = 12; op < 16; op++) begin
            req = make_request(i128_pkg::OP_ADD, '1, '1, '1);
            req.opcode = 4'(op);
            send_request(req);
        end
        end_burst();
    endtask

    task automatic test_random(int count);
        i128_pkg::t_req req;
        for (int i = 0; i < count; i++) begin
            req = make_request(i128_pkg::OP_ADD, random_word(), random_word(),
                               7'($urandom));
            req.opcode = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12))
                                                   : 4'($urandom_range(11));
            send_request(req);
        end
        end_burst();
    endtask

    initial begin
        fail_count  = 0;
        cycle_count = 0;
        idle_pct    = 32;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_req       = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(400);
        idle_pct = 60;
        test_random(400);
        idle_pct = 0;
        test_random(400);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("int128_alu_unit verification clean");
        end else begin
            $display("int128_alu_unit verification failed");
        end
        $finish;
    end

endmodule
